// ===== hw/rtl/swal_pkg.sv =====
// Package: shared constants, state type, register indexes and the sine table.
package swal_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int PHASE_BITS  = 32;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int QUARTER     = SINE_DEPTH / 4;

  localparam int GAIN_FRAC = 24;
  localparam int GAIN_W    = GAIN_FRAC + 4;
  localparam int ACC_W     = SAMPLE_BITS + 6;
  localparam int MUL_A_W   = 32;
  localparam int PROD_W    = MUL_A_W + GAIN_W;
  localparam int QUO_W     = GAIN_FRAC;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [GAIN_W-1:0] UNITY = GAIN_W'(1 << GAIN_FRAC);

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TAYLOR_DIV [5] = '{6, 20, 42, 72, 110};

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE, CFG_WIDTH, CFG_BALANCE, CFG_DEPTH, CFG_PSTEP, CFG_SMOOTH, CFG_RELEASE
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WMUL, ST_WUPD, ST_MMUL, ST_MUPD, ST_RMUL, ST_RUPD, ST_PMUL, ST_PUPD,
    ST_SMUL1, ST_SMUL2, ST_SMUL3, ST_SMUL4, ST_PAN1, ST_PAN2, ST_PAN3, ST_PAN4,
    ST_PEAK, ST_DIV, ST_GSEL, ST_GMUL, ST_GUPD, ST_OLM, ST_OLW, ST_ORM, ST_ORW, ST_DONE
  } state_e;

  typedef logic signed [15:0] sine_t;
  typedef sine_t sine_tab_t [SINE_DEPTH];

  // Quarter-wave Taylor series, Q1.14 result, folded over four quadrants
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint quad, r, x, x2, term, sum, q;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      quad = (i / QUARTER) % 4;
      r    = i % QUARTER;
      if ((quad % 2) == 1) r = QUARTER - r;
      x    = r * HALF_PI_Q30 / QUARTER;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 0; k < 5; k++) begin
        term = ((term * x2) >>> 30) / TAYLOR_DIV[k];
        if ((k % 2) == 1) sum = sum + term;
        else sum = sum - term;
      end
      q = (sum + 32768) >>> 16;
      if (q < 0) q = 0;
      if (q > 16384) q = 16384;
      tab[i] = (quad >= 2) ? 16'(-q) : 16'(q);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== hw/rtl/stereo_width_autopan_limiter.sv =====
// Stereo width, auto-pan and peak limiter: sequencer around one shared multiplier.
// A bypassed frame goes straight from accept to the result; any other frame runs the sequencer.
// Throughput: one frame at a time; the worst case, from one accept to the next,
// is set by the single multiplier (11 products in turn) and the 24-step gain divider.
// A stalled result holds the sequencer in its last state for as long as the stall lasts.
// Reset (rst_ni low, asynchronous): registers to defaults, phase 0, width and safety
// gain at unity, mono blend and pan at 0, no item in flight, output empty.
module stereo_width_autopan_limiter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [swal_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [swal_pkg::SAMPLE_BITS-1:0] right_in_i,
  input  logic                                end_of_block_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [swal_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [swal_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic                                end_of_block_out_o,
  input  logic                                cfg_we_i,
  input  logic [swal_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [swal_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import swal_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [ACC_W-1:0] SAMPLE_ONE = ACC_W'(1) << SAMPLE_BITS;

  // ---- helpers --------------------------------------------------------------
  // round half up, then arithmetic shift
  function automatic logic signed [PROD_W-1:0] rshr(input logic signed [PROD_W-1:0] v,
                                                     input int s);
    return (v + (PROD_W'(1) <<< (s - 1))) >>> s;
  endfunction

  // one-pole follower step with creep and snap
  function automatic logic signed [GAIN_W-1:0] follow_upd(
      input logic signed [GAIN_W-1:0] v, input logic signed [GAIN_W-1:0] tgt,
      input logic signed [PROD_W-1:0] p);
    logic signed [GAIN_W-1:0] d, stp, nv, df;
    logic signed [PROD_W-1:0] rs;
    d   = tgt - v;
    rs  = rshr(p, GAIN_FRAC);
    stp = rs[GAIN_W-1:0];
    if (stp == '0 && d != '0) stp = (d > 0) ? GAIN_W'(1) : {GAIN_W{1'b1}};
    nv = v + stp;
    df = tgt - nv;
    if (df < GAIN_W'(2) && df > -GAIN_W'(2)) nv = tgt;
    return nv;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(SMAX)) return SMAX;
    if (v < PROD_W'(SMIN)) return SMIN;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // ---- configuration registers ---------------------------------------------
  logic [2:0]               mode_q;
  logic [15:0]              wtgt_q;
  logic signed [15:0]       bal_q;
  logic [14:0]              depth_q;
  logic [15:0]              pstep_q;
  logic [23:0]              scoef_q;
  logic [23:0]              rcoef_q;

  // ---- persistent state -----------------------------------------------------
  logic [PHASE_BITS-1:0]    phase_q;
  logic signed [GAIN_W-1:0] ws_q, ms_q, ps_q, g_q, g_d;

  // ---- sequencer and per-frame working registers ----------------------------
  state_e                   state_q, state_d;
  logic                     ov_q;
  logic signed [SAMPLE_BITS-1:0] lin_q, rin_q, res_l_q, res_r_q, lo_q, ro_q;
  logic                     eob_q, eo_q;
  logic signed [ACC_W-1:0]  l_q, r_q, tmp_q;
  logic signed [GAIN_W-1:0] pt_q, pt_d;
  logic [SINE_IDX_W-1:0]    pidx_q, pidx_d;
  logic [ACC_W-1:0]         rem_q, dvs_q, peak;
  logic [ACC_W:0]           remx;
  logic [QUO_W-1:0]         quo_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [PROD_W-1:0] prod_q, mul_p;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [GAIN_W-1:0] mul_b;

  logic stereo, surround, blend, pan_neg, bypass, load_out;
  logic signed [GAIN_W-1:0] wtgt_full, mono_tgt;
  logic signed [ACC_W-1:0]  mid, side, abs_l, abs_r;
  logic signed [PROD_W-1:0] rnd14, rnd24, rnd25;

  assign stereo   = mode_q[0];
  assign surround = mode_q[1];
  assign blend    = mode_q[2];
  assign pan_neg  = ps_q < 0;
  assign wtgt_full = $signed({2'b00, wtgt_q, 10'b0});
  assign mono_tgt  = blend ? UNITY : '0;

  // settled defaults: frame goes straight through, nothing moves
  assign bypass = !surround && !blend && wtgt_q == 16'd16384 && bal_q == '0 &&
                  ws_q == UNITY && ps_q == '0 && ms_q == '0 && g_q == UNITY;

  assign rnd14 = rshr(prod_q, 14);
  assign rnd24 = rshr(prod_q, GAIN_FRAC);
  assign rnd25 = rshr(prod_q, GAIN_FRAC + 1);

  assign mid   = ACC_W'(lin_q) + ACC_W'(rin_q);
  assign side  = rnd24[ACC_W-1:0];
  assign abs_l = l_q < 0 ? -l_q : l_q;
  assign abs_r = r_q < 0 ? -r_q : r_q;
  assign peak  = (abs_r > abs_l) ? abs_r : abs_l;
  assign remx  = {rem_q, 1'b0};

  // pan target: balance plus auto-pan swing, clamped to +-1
  always_comb begin
    logic signed [PROD_W-1:0] rot, pt;
    rot = surround ? rshr(prod_q, 4) : '0;
    pt  = (PROD_W'(bal_q) <<< 10) + rot;
    if (pt > PROD_W'(UNITY)) pt = PROD_W'(UNITY);
    if (pt < -PROD_W'(UNITY)) pt = -PROD_W'(UNITY);
    pt_d = pt[GAIN_W-1:0];
  end

  // equal-power pan table index from the smoothed pan position
  always_comb begin
    logic signed [GAIN_W+SINE_IDX_W-1:0] frac, ix;
    frac = pan_neg ? (GAIN_W+SINE_IDX_W)'(ps_q + UNITY) : (GAIN_W+SINE_IDX_W)'(ps_q);
    ix   = ((frac <<< (SINE_IDX_W - 2)) + ((GAIN_W+SINE_IDX_W)'(1) <<< (GAIN_FRAC - 1)))
           >>> GAIN_FRAC;
    if (ix > (GAIN_W+SINE_IDX_W)'(QUARTER)) ix = (GAIN_W+SINE_IDX_W)'(QUARTER);
    if (ix < 0) ix = '0;
    pidx_d = ix[SINE_IDX_W-1:0];
  end

  // safety gain after the release step
  always_comb begin
    logic signed [GAIN_W-1:0] stp;
    stp = rnd24[GAIN_W-1:0];
    if (stp == '0 && g_q < UNITY) stp = GAIN_W'(1);
    g_d = g_q + stp;
    if (g_d >= UNITY - GAIN_W'(1)) g_d = UNITY;
  end

  // ---- next state and multiplier operand selection --------------------------
  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = bypass ? ST_DONE : ST_WMUL;
      ST_WMUL: begin
        mul_a = MUL_A_W'(wtgt_full - ws_q);
        mul_b = GAIN_W'($signed({1'b0, scoef_q}));
        state_d = ST_WUPD;
      end
      ST_WUPD:  state_d = ST_MMUL;
      ST_MMUL: begin
        mul_a = MUL_A_W'(mono_tgt - ms_q);
        mul_b = GAIN_W'($signed({1'b0, scoef_q}));
        state_d = ST_MUPD;
      end
      ST_MUPD:  state_d = ST_RMUL;
      ST_RMUL: begin
        mul_a = MUL_A_W'(SINE_TAB[phase_q[PHASE_BITS-1 -: SINE_IDX_W]]);
        mul_b = GAIN_W'($signed({1'b0, depth_q}));
        state_d = ST_RUPD;
      end
      ST_RUPD:  state_d = ST_PMUL;
      ST_PMUL: begin
        mul_a = MUL_A_W'(pt_q - ps_q);
        mul_b = GAIN_W'($signed({1'b0, scoef_q}));
        state_d = ST_PUPD;
      end
      ST_PUPD:  state_d = stereo ? ST_SMUL1 : ST_PEAK;
      ST_SMUL1: begin
        mul_a = MUL_A_W'(lin_q) - MUL_A_W'(rin_q);
        mul_b = ws_q;
        state_d = ST_SMUL2;
      end
      ST_SMUL2: state_d = ST_SMUL3;
      ST_SMUL3: begin
        mul_a = MUL_A_W'(tmp_q);
        mul_b = UNITY - ms_q;
        state_d = ST_SMUL4;
      end
      ST_SMUL4: state_d = (ps_q == '0) ? ST_PEAK : ST_PAN1;
      ST_PAN1: begin
        mul_a = pan_neg ? MUL_A_W'(r_q) : MUL_A_W'(l_q);
        mul_b = pan_neg ? GAIN_W'(SINE_TAB[pidx_q + SINE_IDX_W'(QUARTER)])
                        : GAIN_W'(SINE_TAB[pidx_q]);
        state_d = ST_PAN2;
      end
      ST_PAN2:  state_d = ST_PAN3;
      ST_PAN3: begin
        mul_a = pan_neg ? MUL_A_W'(r_q) : MUL_A_W'(l_q);
        mul_b = pan_neg ? GAIN_W'(SINE_TAB[pidx_q])
                        : GAIN_W'(SINE_TAB[pidx_q + SINE_IDX_W'(QUARTER)]);
        state_d = ST_PAN4;
      end
      ST_PAN4:  state_d = ST_PEAK;
      ST_PEAK:  state_d = (peak > SAMPLE_ONE) ? ST_DIV : ST_GMUL;
      ST_DIV:   if (cnt_q == '0) state_d = ST_GSEL;
      ST_GSEL:  state_d = (GAIN_W'(quo_q) < g_q) ? ST_OLM : ST_GMUL;
      ST_GMUL: begin
        mul_a = MUL_A_W'(UNITY - g_q);
        mul_b = GAIN_W'($signed({1'b0, rcoef_q}));
        state_d = ST_GUPD;
      end
      ST_GUPD:  state_d = ST_OLM;
      ST_OLM: begin
        mul_a = MUL_A_W'(l_q);
        mul_b = g_q;
        state_d = ST_OLW;
      end
      ST_OLW:   state_d = ST_ORM;
      ST_ORM: begin
        mul_a = MUL_A_W'(r_q);
        mul_b = g_q;
        state_d = ST_ORW;
      end
      ST_ORW:   state_d = ST_DONE;
      ST_DONE:  if (!ov_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign mul_p      = mul_a * mul_b;
  assign in_ready_o = state_q == ST_IDLE;
  assign load_out   = state_q == ST_DONE && (!ov_q || out_ready_i);

  // ---- control and architectural state -------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      mode_q  <= 3'd1;
      wtgt_q  <= 16'd16384;
      bal_q   <= '0;
      depth_q <= 15'd10650;
      pstep_q <= 16'd7457;
      scoef_q <= 24'd23287;
      rcoef_q <= 24'd3495;
      phase_q <= '0;
      ws_q    <= UNITY;
      ms_q    <= '0;
      ps_q    <= '0;
      g_q     <= UNITY;
    end else begin
      state_q <= state_d;
      if (load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MODE:    mode_q  <= cfg_wdata_i[2:0];
          CFG_WIDTH:   wtgt_q  <= cfg_wdata_i[15:0];
          CFG_BALANCE: bal_q   <= cfg_wdata_i[15:0];
          CFG_DEPTH:   depth_q <= cfg_wdata_i[14:0];
          CFG_PSTEP:   pstep_q <= cfg_wdata_i[15:0];
          CFG_SMOOTH:  scoef_q <= cfg_wdata_i[23:0];
          CFG_RELEASE: rcoef_q <= cfg_wdata_i[23:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_WUPD: ws_q <= follow_upd(ws_q, wtgt_full, prod_q);
        ST_MUPD: ms_q <= follow_upd(ms_q, mono_tgt, prod_q);
        ST_PUPD: begin
          ps_q <= follow_upd(ps_q, pt_q, prod_q);
          if (surround) phase_q <= phase_q + PHASE_BITS'(pstep_q);
        end
        ST_GSEL: if (GAIN_W'(quo_q) < g_q) begin
          g_q <= (GAIN_W'(quo_q) >= UNITY - GAIN_W'(1)) ? UNITY : GAIN_W'(quo_q);
        end
        ST_GUPD: g_q <= g_d;
        default: ;
      endcase
    end
  end

  // ---- datapath payload -----------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        lin_q   <= left_in_i;
        rin_q   <= right_in_i;
        eob_q   <= end_of_block_i;
        res_l_q <= left_in_i;
        res_r_q <= mode_q[0] ? right_in_i : '0;
      end
      ST_RUPD:  pt_q <= pt_d;
      ST_PUPD: if (!stereo) begin
        l_q <= ACC_W'(lin_q) <<< 1;
        r_q <= '0;
      end
      ST_SMUL2: tmp_q <= rnd24[ACC_W-1:0];
      ST_SMUL4: begin
        l_q    <= mid + side;
        r_q    <= mid - side;
        pidx_q <= pidx_d;
      end
      ST_PAN2: begin
        if (pan_neg) l_q <= l_q + rnd14[ACC_W-1:0];
        else r_q <= r_q + rnd14[ACC_W-1:0];
      end
      ST_PAN4: begin
        if (pan_neg) r_q <= rnd14[ACC_W-1:0];
        else l_q <= rnd14[ACC_W-1:0];
      end
      ST_PEAK: begin
        rem_q <= SAMPLE_ONE;
        dvs_q <= peak;
        quo_q <= '0;
        cnt_q <= CNT_W'(QUO_W - 1);
      end
      ST_DIV: begin
        // restoring divide of unity * full scale by the peak, one bit per cycle
        if (remx >= {1'b0, dvs_q}) begin
          rem_q <= ACC_W'(remx - {1'b0, dvs_q});
          quo_q <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_q <= remx[ACC_W-1:0];
          quo_q <= {quo_q[QUO_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CNT_W'(1);
      end
      ST_OLW: res_l_q <= sat(rnd25);
      ST_ORW: res_r_q <= stereo ? sat(rnd25) : '0;
      default: ;
    endcase
    if (load_out) begin
      lo_q <= res_l_q;
      ro_q <= res_r_q;
      eo_q <= eob_q;
    end
  end

  assign out_valid_o        = ov_q;
  assign left_out_o         = lo_q;
  assign right_out_o        = ro_q;
  assign end_of_block_out_o = eo_q;

endmodule

// ===== hw/rtl/swal_checker.sv =====
// Port-level checker for the limiter, bound to the top level.
module swal_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [swal_pkg::SAMPLE_BITS-1:0] left_out_o,
  input logic signed [swal_pkg::SAMPLE_BITS-1:0] right_out_o,
  input logic                                end_of_block_out_o
);
  import swal_pkg::*;

  // one frame at a time: busy straight after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a frame is in progress");

  // a new result is only produced by a busy sequencer
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_out_o) &&
      $stable(right_out_o) && $stable(end_of_block_out_o))
    else $error("stalled result changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind stereo_width_autopan_limiter swal_checker u_swal_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .left_out_o         (left_out_o),
  .right_out_o        (right_out_o),
  .end_of_block_out_o (end_of_block_out_o)
);
